@@ src/sme_pkg.sv @@
// ----------------------------------------------------------------------------
// sme_pkg
// shared types and codes for the stack machine executor
// ----------------------------------------------------------------------------
package sme_pkg;

    typedef struct packed {
        logic [4:0]         instr_opcode;
        logic signed [31:0] instr_arg;
    } instr_t;

    typedef struct packed {
        logic [9:0]         next_ip;
        logic               print_valid;
        logic signed [31:0] print_value;
        logic               halted;
        logic [2:0]         fault_code;
    } result_t;

    localparam logic [4:0] OP_PUSH = 5'd0;
    localparam logic [4:0] OP_POP  = 5'd1;
    localparam logic [4:0] OP_DUP  = 5'd2;
    localparam logic [4:0] OP_ADD  = 5'd3;
    localparam logic [4:0] OP_SUB  = 5'd4;
    localparam logic [4:0] OP_MUL  = 5'd5;
    localparam logic [4:0] OP_DIV  = 5'd6;
    localparam logic [4:0] OP_JMP  = 5'd7;
    localparam logic [4:0] OP_JIT  = 5'd8;
    localparam logic [4:0] OP_JIF  = 5'd9;
    localparam logic [4:0] OP_CALL = 5'd10;
    localparam logic [4:0] OP_RET  = 5'd11;
    localparam logic [4:0] OP_EQ   = 5'd12;
    localparam logic [4:0] OP_GT   = 5'd13;
    localparam logic [4:0] OP_GE   = 5'd14;
    localparam logic [4:0] OP_LT   = 5'd15;
    localparam logic [4:0] OP_LE   = 5'd16;
    localparam logic [4:0] OP_NE   = 5'd17;
    localparam logic [4:0] OP_STO  = 5'd18;
    localparam logic [4:0] OP_RCL  = 5'd19;
    localparam logic [4:0] OP_STL  = 5'd20;
    localparam logic [4:0] OP_RCE  = 5'd21;
    localparam logic [4:0] OP_ALC  = 5'd22;
    localparam logic [4:0] OP_FRE  = 5'd23;
    localparam logic [4:0] OP_SAVE = 5'd24;
    localparam logic [4:0] OP_REST = 5'd25;
    localparam logic [4:0] OP_END  = 5'd26;
    localparam logic [4:0] OP_PRN  = 5'd27;

    localparam logic [2:0] FLT_OK   = 3'd0;
    localparam logic [2:0] FLT_UNF  = 3'd1;
    localparam logic [2:0] FLT_OVF  = 3'd2;
    localparam logic [2:0] FLT_EXC  = 3'd3;
    localparam logic [2:0] FLT_ADDR = 3'd4;
    localparam logic [2:0] FLT_DIVZ = 3'd5;

    typedef enum logic [3:0] {
        ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV,
        ALU_EQ, ALU_GT, ALU_GE, ALU_LT, ALU_LE, ALU_NE
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

endpackage

@@ src/sme_alu.sv @@
// ----------------------------------------------------------------------------
// sme_alu
// shared arithmetic unit: add, sub, compare, multiply, iterative divide
// ----------------------------------------------------------------------------
module sme_alu (
    input  logic              clk,
    input  logic              rst_n,
    input  sme_pkg::alu_req_t req,
    input  logic [31:0]       a,
    input  logic [31:0]       b,
    output logic              done,
    output logic [31:0]       res
);
    import sme_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] dvs_reg;
    logic        neg_reg;
    logic [31:0] res_reg;

    logic [32:0] rem_sh;
    logic [32:0] rem_sub;
    logic        bit_q;
    logic [31:0] quo_new;
    logic [31:0] simple_res;

    // one restoring divide step
    assign rem_sh  = {rem_reg, quo_reg[31]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};
    assign bit_q   = !rem_sub[32];
    assign quo_new = {quo_reg[30:0], bit_q};

    always_comb
    begin
        case (req.op)
            ALU_ADD: simple_res = a + b;
            ALU_SUB: simple_res = a - b;
            ALU_MUL: simple_res = 32'(a * b);
            ALU_EQ:  simple_res = {31'd0, a == b};
            ALU_GT:  simple_res = {31'd0, $signed(a) >  $signed(b)};
            ALU_GE:  simple_res = {31'd0, $signed(a) >= $signed(b)};
            ALU_LT:  simple_res = {31'd0, $signed(a) <  $signed(b)};
            ALU_LE:  simple_res = {31'd0, $signed(a) <= $signed(b)};
            ALU_NE:  simple_res = {31'd0, a != b};
            default: simple_res = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && req.op == ALU_DIV)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (req.start)
            begin
                done_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && req.op == ALU_DIV)
        begin
            rem_reg <= '0;
            quo_reg <= a[31] ? -a : a;
            dvs_reg <= b[31] ? -b : b;
            neg_reg <= a[31] ^ b[31];
        end
        else if (req.start)
        begin
            res_reg <= simple_res;
        end
        else if (busy_reg)
        begin
            rem_reg <= bit_q ? rem_sub[31:0] : rem_sh[31:0];
            quo_reg <= quo_new;
            if (cnt_reg == 5'd31)
                res_reg <= neg_reg ? -quo_new : quo_new;
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("alu done held for more than one cycle");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !req.start)
        else $error("alu started while divide in progress");
    a_busy_ends: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && cnt_reg == 5'd31 |=> done_reg && !busy_reg)
        else $error("divide did not finish after last step");

endmodule

@@ src/stack_machine_executor.sv @@
// ----------------------------------------------------------------------------
// stack_machine_executor
// executes one stack machine instruction per input beat
// ----------------------------------------------------------------------------
// usage:
//   instr channel (instr_valid/instr_ready) carries one fetched instruction
//   per beat; result channel (result_valid/result_ready) returns one beat per
//   instruction with the next fetch address, print value, halt and fault
// sequence: accept, execute and output states for each instruction; call
//   adds a state for its second exec stack push; arithmetic and compare
//   wait in the alu state for the shared alu, where divide runs the
//   bit-serial divide loop
// throughput: one instruction at a time; instr_ready is high only while
//   the sequencer waits for a new instruction
// stall: a finished result waits in the output register; a new instruction
//   is accepted meanwhile, and its result waits until the output is taken
// reset: both stacks empty, frame base and instruction pointer zero, not
//   halted; stack and memory contents are undefined until written
// after end every beat returns the frozen instruction pointer and halted
// ----------------------------------------------------------------------------
module stack_machine_executor #(
    parameter int DATA_DEPTH = 128,
    parameter int EXEC_DEPTH = 128,
    parameter int MEM_WORDS  = 128,
    parameter int PROG_WORDS = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             instr_valid,
    output logic             instr_ready,
    input  sme_pkg::instr_t  instr,
    output logic             result_valid,
    input  logic             result_ready,
    output sme_pkg::result_t result
);
    import sme_pkg::*;

    localparam int DTW = $clog2(DATA_DEPTH + 1);
    localparam int DIW = $clog2(DATA_DEPTH);
    localparam int ETW = $clog2(EXEC_DEPTH + 1);
    localparam int EW  = $clog2(EXEC_DEPTH);
    localparam int MW  = $clog2(MEM_WORDS);
    localparam int PW  = $clog2(PROG_WORDS);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_ALU   = 5'b00100,
        S_PUSH2 = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    // stack and data memories
    logic [31:0] data_stack [DATA_DEPTH];
    logic [31:0] exec_stack [EXEC_DEPTH];
    logic [31:0] data_memory [MEM_WORDS];

    state_t          state_reg, state_next;
    logic [DTW-1:0]  dt_reg, dt_next;
    logic [ETW-1:0]  et_reg, et_next;
    logic [EW-1:0]   fb_reg, fb_next;
    logic [PW-1:0]   ip_reg, ip_next;
    logic            halt_reg, halt_next;
    logic [4:0]      op_reg;
    logic [31:0]     arg_reg;
    logic            pv_reg, pv_next;
    logic [31:0]     pval_reg, pval_next;
    logic [2:0]      flt_reg, flt_next;
    logic            result_valid_reg;
    result_t         result_reg;

    // read data, registered at the memory
    logic [31:0] ds_rd_a, ds_rd_b, es_rd_a, es_rd_b, dm_rd;

    logic [DTW-1:0] dt_m1, dt_m2;
    logic [ETW-1:0] et_m1, et_m2;
    logic [33:0]    fidx_in, fidx;
    logic           fidx_ok;
    logic [33:0]    nt;
    logic           nt_ok;
    logic           tgt_ok, mem_ok, dfull;
    logic [PW-1:0]  ip_seq, ret_seq;
    logic [31:0]    ip_ext, ip32;
    logic           take;

    logic           ds_we, es_we, dm_we;
    logic [DIW-1:0] ds_wa;
    logic [EW-1:0]  es_wa;
    logic [31:0]    ds_wd, es_wd;

    alu_req_t    alu_req;
    alu_op_t     alu_op;
    logic        alu_start;
    logic        alu_done;
    logic [31:0] alu_res;
    logic        out_load;

    assign dt_m1 = dt_reg - DTW'(1);
    assign dt_m2 = dt_reg - DTW'(2);
    assign et_m1 = et_reg - ETW'(1);
    assign et_m2 = et_reg - ETW'(2);

    // frame-relative index, once from the port for the read, once held
    assign fidx_in = {{2{instr.instr_arg[31]}}, instr.instr_arg}
                   + {{(34 - EW){1'b0}}, fb_reg};
    assign fidx    = {{2{arg_reg[31]}}, arg_reg} + {{(34 - EW){1'b0}}, fb_reg};
    assign fidx_ok = !fidx[33] && fidx < 34'(EXEC_DEPTH);

    // new exec top for allocate and free
    assign nt    = (op_reg == OP_ALC)
                 ? {{(34 - ETW){1'b0}}, et_reg} + {{2{arg_reg[31]}}, arg_reg}
                 : {{(34 - ETW){1'b0}}, et_reg} - {{2{arg_reg[31]}}, arg_reg};
    assign nt_ok = !nt[33] && nt <= 34'(EXEC_DEPTH);

    assign tgt_ok = !arg_reg[31] && arg_reg < 32'(PROG_WORDS);
    assign mem_ok = !arg_reg[31] && arg_reg < 32'(MEM_WORDS);
    assign dfull  = dt_reg == DTW'(DATA_DEPTH);

    assign ip_seq  = (ip_reg == PW'(PROG_WORDS - 1)) ? '0 : ip_reg + PW'(1);
    assign ret_seq = (es_rd_b[PW-1:0] == PW'(PROG_WORDS - 1))
                   ? '0 : es_rd_b[PW-1:0] + PW'(1);
    assign ip32    = {{(32 - PW){1'b0}}, ip_reg};
    assign ip_ext  = ip32;
    assign take    = (op_reg == OP_JIT) == (ds_rd_a != 32'd0);

    // memory reads in the accept cycle; rce and data memory use the port
    always_ff @(posedge clk)
    begin
        ds_rd_a <= data_stack[dt_m1[DIW-1:0]];
        ds_rd_b <= data_stack[dt_m2[DIW-1:0]];
        es_rd_a <= exec_stack[(instr.instr_opcode == OP_RCE) ? fidx_in[EW-1:0]
                                                             : et_m1[EW-1:0]];
        es_rd_b <= exec_stack[et_m2[EW-1:0]];
        dm_rd   <= data_memory[instr.instr_arg[MW-1:0]];
        if (ds_we)
            data_stack[ds_wa] <= ds_wd;
        if (es_we)
            exec_stack[es_wa] <= es_wd;
        if (dm_we)
            data_memory[arg_reg[MW-1:0]] <= ds_rd_a;
    end

    assign alu_req = '{start: alu_start, op: alu_op};

    sme_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .a     (ds_rd_b),
        .b     (ds_rd_a),
        .done  (alu_done),
        .res   (alu_res)
    );

    always_comb
    begin
        case (op_reg)
            OP_ADD:  alu_op = ALU_ADD;
            OP_SUB:  alu_op = ALU_SUB;
            OP_MUL:  alu_op = ALU_MUL;
            OP_DIV:  alu_op = ALU_DIV;
            OP_EQ:   alu_op = ALU_EQ;
            OP_GT:   alu_op = ALU_GT;
            OP_GE:   alu_op = ALU_GE;
            OP_LT:   alu_op = ALU_LT;
            OP_LE:   alu_op = ALU_LE;
            default: alu_op = ALU_NE;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        dt_next       = dt_reg;
        et_next       = et_reg;
        fb_next       = fb_reg;
        ip_next       = ip_reg;
        halt_next     = halt_reg;
        pv_next       = pv_reg;
        pval_next     = pval_reg;
        flt_next      = flt_reg;
        ds_we         = 1'b0;
        ds_wa         = dt_reg[DIW-1:0];
        ds_wd         = arg_reg;
        es_we         = 1'b0;
        es_wa         = et_reg[EW-1:0];
        es_wd         = ip_ext;
        dm_we         = 1'b0;
        alu_start     = 1'b0;
        out_load      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (instr_valid)
                begin
                    pv_next    = 1'b0;
                    pval_next  = '0;
                    flt_next   = FLT_OK;
                    state_next = halt_reg ? S_OUT : S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_OUT;
                ip_next    = ip_seq;
                case (op_reg)
                    OP_PUSH:
                    begin
                        if (dfull)
                            flt_next = FLT_OVF;
                        else
                        begin
                            ds_we   = 1'b1;
                            dt_next = dt_reg + DTW'(1);
                        end
                    end
                    OP_POP:
                    begin
                        if (dt_reg == '0)
                            flt_next = FLT_UNF;
                        else
                            dt_next = dt_m1;
                    end
                    OP_DUP:
                    begin
                        if (dt_reg == '0)
                            flt_next = FLT_UNF;
                        else if (dfull)
                            flt_next = FLT_OVF;
                        else
                        begin
                            ds_we   = 1'b1;
                            ds_wd   = ds_rd_a;
                            dt_next = dt_reg + DTW'(1);
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV,
                    OP_EQ, OP_GT, OP_GE, OP_LT, OP_LE, OP_NE:
                    begin
                        if (dt_reg < DTW'(2))
                            flt_next = FLT_UNF;
                        else if (op_reg == OP_DIV && ds_rd_a == 32'd0)
                            flt_next = FLT_DIVZ;
                        else
                        begin
                            alu_start     = 1'b1;
                            state_next    = S_ALU;
                        end
                    end
                    OP_JMP:
                    begin
                        if (!tgt_ok)
                            flt_next = FLT_ADDR;
                        else
                            ip_next = arg_reg[PW-1:0];
                    end
                    OP_JIT, OP_JIF:
                    begin
                        if (dt_reg == '0)
                            flt_next = FLT_UNF;
                        else if (take && !tgt_ok)
                            flt_next = FLT_ADDR;
                        else
                        begin
                            if (take)
                                ip_next = arg_reg[PW-1:0];
                            dt_next = dt_m1;
                        end
                    end
                    OP_CALL:
                    begin
                        if (et_reg > ETW'(EXEC_DEPTH - 2))
                            flt_next = FLT_EXC;
                        else if (!tgt_ok)
                            flt_next = FLT_ADDR;
                        else
                        begin
                            es_we      = 1'b1;
                            et_next    = et_reg + ETW'(1);
                            ip_next    = arg_reg[PW-1:0];
                            state_next = S_PUSH2;
                        end
                    end
                    OP_RET:
                    begin
                        if (et_reg < ETW'(2))
                            flt_next = FLT_EXC;
                        else if (es_rd_a >= 32'(EXEC_DEPTH)
                                 || es_rd_b >= 32'(PROG_WORDS))
                            flt_next = FLT_EXC;
                        else
                        begin
                            et_next = et_m2;
                            fb_next = es_rd_a[EW-1:0];
                            ip_next = ret_seq;
                        end
                    end
                    OP_STO:
                    begin
                        if (dt_reg == '0)
                            flt_next = FLT_UNF;
                        else if (!mem_ok)
                            flt_next = FLT_ADDR;
                        else
                        begin
                            dm_we   = 1'b1;
                            dt_next = dt_m1;
                        end
                    end
                    OP_RCL:
                    begin
                        if (dfull)
                            flt_next = FLT_OVF;
                        else if (!mem_ok)
                            flt_next = FLT_ADDR;
                        else
                        begin
                            ds_we   = 1'b1;
                            ds_wd   = dm_rd;
                            dt_next = dt_reg + DTW'(1);
                        end
                    end
                    OP_STL:
                    begin
                        if (dt_reg == '0)
                            flt_next = FLT_UNF;
                        else if (!fidx_ok)
                            flt_next = FLT_ADDR;
                        else
                        begin
                            es_we   = 1'b1;
                            es_wa   = fidx[EW-1:0];
                            es_wd   = ds_rd_a;
                            dt_next = dt_m1;
                        end
                    end
                    OP_RCE:
                    begin
                        if (dfull)
                            flt_next = FLT_OVF;
                        else if (!fidx_ok)
                            flt_next = FLT_ADDR;
                        else
                        begin
                            ds_we   = 1'b1;
                            ds_wd   = es_rd_a;
                            dt_next = dt_reg + DTW'(1);
                        end
                    end
                    OP_ALC, OP_FRE:
                    begin
                        if (!nt_ok)
                            flt_next = FLT_EXC;
                        else
                            et_next = nt[ETW-1:0];
                    end
                    OP_SAVE:
                    begin
                        if (et_reg == ETW'(EXEC_DEPTH))
                            flt_next = FLT_EXC;
                        else
                        begin
                            es_we   = 1'b1;
                            es_wd   = {{(32 - EW){1'b0}}, fb_reg};
                            fb_next = et_reg[EW-1:0];
                            et_next = et_reg + ETW'(1);
                        end
                    end
                    OP_REST:
                    begin
                        if (et_reg == '0 || es_rd_a >= 32'(EXEC_DEPTH))
                            flt_next = FLT_EXC;
                        else
                        begin
                            et_next = et_m1;
                            fb_next = es_rd_a[EW-1:0];
                        end
                    end
                    OP_END:
                    begin
                        halt_next = 1'b1;
                        ip_next   = ip_reg;
                    end
                    OP_PRN:
                    begin
                        if (dt_reg == '0)
                            flt_next = FLT_UNF;
                        else
                        begin
                            pv_next   = 1'b1;
                            pval_next = ds_rd_a;
                            dt_next   = dt_m1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_ALU:
            begin
                if (alu_done)
                begin
                    ds_we      = 1'b1;
                    ds_wa      = dt_m2[DIW-1:0];
                    ds_wd      = alu_res;
                    dt_next    = dt_m1;
                    state_next = S_OUT;
                end
            end
            S_PUSH2:
            begin
                // second half of call: saved frame base
                es_we      = 1'b1;
                es_wd      = {{(32 - EW){1'b0}}, fb_reg};
                fb_next    = et_reg[EW-1:0];
                et_next    = et_reg + ETW'(1);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            dt_reg           <= '0;
            et_reg           <= '0;
            fb_reg           <= '0;
            ip_reg           <= '0;
            halt_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dt_reg    <= dt_next;
            et_reg    <= et_next;
            fb_reg    <= fb_next;
            ip_reg    <= ip_next;
            halt_reg  <= halt_next;
            if (out_load)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && instr_valid)
        begin
            op_reg  <= instr.instr_opcode;
            arg_reg <= instr.instr_arg;
        end
        pv_reg   <= pv_next;
        pval_reg <= pval_next;
        flt_reg  <= flt_next;
        if (out_load)
        begin
            result_reg.next_ip     <= ip_ext[9:0];
            result_reg.print_valid <= pv_reg;
            result_reg.print_value <= pval_reg;
            result_reg.halted      <= halt_reg;
            result_reg.fault_code  <= flt_reg;
        end
    end

    assign instr_ready  = state_reg == S_IDLE;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_data_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dt_reg <= DTW'(DATA_DEPTH))
        else $error("data stack top past depth");
    a_exec_bound: assert property (@(posedge clk) disable iff (!rst_n)
        et_reg <= ETW'(EXEC_DEPTH))
        else $error("exec stack top past depth");
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg)
        else $error("halt flag cleared");
    a_fault_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC && flt_next != FLT_OK
        |=> $stable(dt_reg) && $stable(et_reg) && $stable(fb_reg))
        else $error("faulting instruction changed stack state");

endmodule
